// ===== rtl/mrpt_pkg.sv =====
// Shared constants, command and status types for the Miller-Rabin test unit.
package mrpt_pkg;

   localparam int VALUE_WIDTH = 63;
   localparam int CAND_WIDTH  = 63;
   localparam int CFG_WIDTH   = 4;
   localparam int MAX_ROUNDS  = 10;
   localparam int COUNT_WIDTH = $clog2(VALUE_WIDTH);
   localparam int ROUND_WIDTH = $clog2(MAX_ROUNDS + 1);
   localparam logic [CFG_WIDTH-1:0] ROUND_COUNT_RESET = CFG_WIDTH'(10);

   typedef logic [VALUE_WIDTH-1:0] value_type;

   // datapath operations
   localparam logic [3:0] OP_NONE       = 4'd0;
   localparam logic [3:0] OP_LOAD       = 4'd1;
   localparam logic [3:0] OP_STRIP      = 4'd2;
   localparam logic [3:0] OP_WITNESS    = 4'd3;
   localparam logic [3:0] OP_REDUCE     = 4'd4;
   localparam logic [3:0] OP_POW_INIT   = 4'd5;
   localparam logic [3:0] OP_WB_ACC     = 4'd6;
   localparam logic [3:0] OP_WB_BASE    = 4'd7;
   localparam logic [3:0] OP_WB_SQ      = 4'd8;
   localparam logic [3:0] OP_NEXT_ROUND = 4'd9;

   // multiplier operand selection
   localparam logic [1:0] MSEL_ACC_BASE  = 2'd0;
   localparam logic [1:0] MSEL_BASE_BASE = 2'd1;
   localparam logic [1:0] MSEL_ACC_ACC   = 2'd2;

   typedef struct packed {
      logic [3:0] op;
      logic       mul_start;
      logic [1:0] mul_sel;
   } cmd_type;

   typedef struct packed {
      logic n_lt2;
      logic n_eq2;
      logic n_odd;
      logic r_lsb;
      logic a_ge_n;
      logic a_zero;
      logic rounds_done;
      logic e_zero;
      logic e_lsb;
      logic j_eq_d;
      logic mul_done;
      logic sq_fail;
      logic acc_one;
   } status_type;

   // first ten primes, used as witnesses in order
   function automatic value_type witness(input logic [ROUND_WIDTH-1:0] idx);
      logic [7:0] w;
      case (idx)
         ROUND_WIDTH'(0): w = 8'd2;
         ROUND_WIDTH'(1): w = 8'd3;
         ROUND_WIDTH'(2): w = 8'd5;
         ROUND_WIDTH'(3): w = 8'd7;
         ROUND_WIDTH'(4): w = 8'd11;
         ROUND_WIDTH'(5): w = 8'd13;
         ROUND_WIDTH'(6): w = 8'd17;
         ROUND_WIDTH'(7): w = 8'd19;
         ROUND_WIDTH'(8): w = 8'd23;
         ROUND_WIDTH'(9): w = 8'd29;
         default:         w = 8'd2;
      endcase
      return VALUE_WIDTH'(w);
   endfunction

endpackage

// ===== rtl/mrpt_modmul.sv =====
// Shift-and-add modular multiplier, one bit of the multiplier per cycle.
module mrpt_modmul (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  mrpt_pkg::value_type x,
   input  mrpt_pkg::value_type y,
   input  mrpt_pkg::value_type m,
   output logic                done,
   output mrpt_pkg::value_type product
);
   import mrpt_pkg::*;

   value_type x_ff, x_in;
   value_type y_ff, y_in;
   value_type acc_ff, acc_in;
   logic      busy_ff, busy_in;

   // operands are below m, so one conditional subtract brings the sum back
   function automatic value_type add_mod(input value_type a, input value_type b,
                                         input value_type md);
      logic [VALUE_WIDTH:0] sum;
      logic [VALUE_WIDTH:0] diff;
      sum  = {1'b0, a} + {1'b0, b};
      diff = sum - {1'b0, md};
      if (sum >= {1'b0, md}) begin
         return diff[VALUE_WIDTH-1:0];
      end
      return sum[VALUE_WIDTH-1:0];
   endfunction

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      busy_in = busy_ff;
      if (start) begin
         x_in    = x;
         y_in    = y;
         acc_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (y_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            if (y_ff[0]) begin
               acc_in = add_mod(acc_ff, x_ff, m);
            end
            x_in = add_mod(x_ff, x_ff, m);
            y_in = y_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
   end

   assign done    = busy_ff && (y_ff == '0);
   assign product = acc_ff;

endmodule

// ===== rtl/mrpt_datapath.sv =====
// Datapath: candidate, exponent, witness and accumulator registers and the multiplier.
module mrpt_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mrpt_pkg::cmd_type                     cmd,
   output mrpt_pkg::status_type                  status,
   input  logic [mrpt_pkg::CAND_WIDTH-1:0]       req_candidate,
   input  logic                                  csr_write_enable,
   input  logic [mrpt_pkg::CFG_WIDTH-1:0]        csr_write_data
);
   import mrpt_pkg::*;

   logic [CFG_WIDTH-1:0]   round_count_ff;
   value_type              n_ff, n_in;
   value_type              nm1_ff, nm1_in;
   value_type              r_ff, r_in;
   value_type              e_ff, e_in;
   value_type              a_ff, a_in;
   value_type              acc_ff, acc_in;
   value_type              base_ff, base_in;
   logic [COUNT_WIDTH-1:0] d_ff, d_in;
   logic [COUNT_WIDTH-1:0] j_ff, j_in;
   logic [ROUND_WIDTH-1:0] round_ff, round_in;
   logic [ROUND_WIDTH-1:0] rounds_ff, rounds_in;
   value_type              cand;
   value_type              mul_x, mul_y, product;
   logic                   mul_done;

   assign cand = req_candidate[VALUE_WIDTH-1:0];

   always_comb begin
      if (round_count_ff == '0) begin
         rounds_in = ROUND_WIDTH'(1);
      end else if (round_count_ff > CFG_WIDTH'(MAX_ROUNDS)) begin
         rounds_in = ROUND_WIDTH'(MAX_ROUNDS);
      end else begin
         rounds_in = ROUND_WIDTH'(round_count_ff);
      end
   end

   always_comb begin
      mul_x = acc_ff;
      mul_y = base_ff;
      case (cmd.mul_sel)
         MSEL_ACC_BASE: begin
            mul_x = acc_ff;
            mul_y = base_ff;
         end
         MSEL_BASE_BASE: begin
            mul_x = base_ff;
            mul_y = base_ff;
         end
         MSEL_ACC_ACC: begin
            mul_x = acc_ff;
            mul_y = acc_ff;
         end
         default: begin
            mul_x = acc_ff;
            mul_y = base_ff;
         end
      endcase
   end

   mrpt_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .x       (mul_x),
      .y       (mul_y),
      .m       (n_ff),
      .done    (mul_done),
      .product (product)
   );

   always_comb begin
      n_in     = n_ff;
      nm1_in   = nm1_ff;
      r_in     = r_ff;
      e_in     = e_ff;
      a_in     = a_ff;
      acc_in   = acc_ff;
      base_in  = base_ff;
      d_in     = d_ff;
      j_in     = j_ff;
      round_in = round_ff;
      case (cmd.op)
         OP_NONE: begin
         end
         OP_LOAD: begin
            n_in     = cand;
            nm1_in   = cand - VALUE_WIDTH'(1);
            r_in     = cand - VALUE_WIDTH'(1);
            d_in     = '0;
            round_in = '0;
         end
         OP_STRIP: begin
            r_in = r_ff >> 1;
            d_in = d_ff + COUNT_WIDTH'(1);
         end
         OP_WITNESS: begin
            a_in = witness(round_ff);
         end
         OP_REDUCE: begin
            a_in = a_ff - n_ff;
         end
         OP_POW_INIT: begin
            acc_in  = VALUE_WIDTH'(1);
            base_in = a_ff;
            e_in    = r_ff;
            j_in    = '0;
         end
         OP_WB_ACC: begin
            acc_in = product;
         end
         OP_WB_BASE: begin
            base_in = product;
            e_in    = e_ff >> 1;
         end
         OP_WB_SQ: begin
            acc_in = product;
            j_in   = j_ff + COUNT_WIDTH'(1);
         end
         OP_NEXT_ROUND: begin
            round_in = round_ff + ROUND_WIDTH'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         round_count_ff <= ROUND_COUNT_RESET;
      end else if (csr_write_enable) begin
         round_count_ff <= csr_write_data;
      end
      if (cmd.op == OP_LOAD) begin
         rounds_ff <= rounds_in;
      end
      n_ff     <= n_in;
      nm1_ff   <= nm1_in;
      r_ff     <= r_in;
      e_ff     <= e_in;
      a_ff     <= a_in;
      acc_ff   <= acc_in;
      base_ff  <= base_in;
      d_ff     <= d_in;
      j_ff     <= j_in;
      round_ff <= round_in;
   end

   always_comb begin
      status.n_lt2       = (n_ff[VALUE_WIDTH-1:1] == '0);
      status.n_eq2       = (n_ff == VALUE_WIDTH'(2));
      status.n_odd       = n_ff[0];
      status.r_lsb       = r_ff[0];
      status.a_ge_n      = (a_ff >= n_ff);
      status.a_zero      = (a_ff == '0);
      status.rounds_done = (round_ff == rounds_ff);
      status.e_zero      = (e_ff == '0);
      status.e_lsb       = e_ff[0];
      status.j_eq_d      = (j_ff == d_ff);
      status.mul_done    = mul_done;
      // a square of one from anything but one or minus one exposes a composite
      status.sq_fail     = (product == VALUE_WIDTH'(1)) && (acc_ff != VALUE_WIDTH'(1))
                           && (acc_ff != nm1_ff);
      status.acc_one     = (acc_ff == VALUE_WIDTH'(1));
   end

endmodule

// ===== rtl/mrpt_ctrl.sv =====
// Controller: sequences the trial rounds and holds the result register.
module mrpt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_is_prime,
   output mrpt_pkg::cmd_type    cmd,
   input  mrpt_pkg::status_type status
);
   import mrpt_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_CLASSIFY  = 4'd1;
   localparam logic [3:0] S_STRIP     = 4'd2;
   localparam logic [3:0] S_WITNESS   = 4'd3;
   localparam logic [3:0] S_REDUCE    = 4'd4;
   localparam logic [3:0] S_POW_BIT   = 4'd5;
   localparam logic [3:0] S_WAIT_ACC  = 4'd6;
   localparam logic [3:0] S_POW_SQR   = 4'd7;
   localparam logic [3:0] S_WAIT_BASE = 4'd8;
   localparam logic [3:0] S_SQ_CHECK  = 4'd9;
   localparam logic [3:0] S_WAIT_SQ   = 4'd10;
   localparam logic [3:0] S_DONE      = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       res_ff, res_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       is_prime_ff, is_prime_in;

   assign req_ready    = (state_ff == S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = is_prime_ff;

   always_comb begin
      state_in      = state_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      is_prime_in   = is_prime_ff;
      cmd.op        = OP_NONE;
      cmd.mul_start = 1'b0;
      cmd.mul_sel   = MSEL_ACC_BASE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_CLASSIFY;
            end
         end
         S_CLASSIFY: begin
            if (status.n_lt2 || (!status.n_eq2 && !status.n_odd)) begin
               res_in   = 1'b0;
               state_in = S_DONE;
            end else if (status.n_eq2) begin
               res_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_STRIP;
            end
         end
         S_STRIP: begin
            // shift out the factors of two from n-1
            if (!status.r_lsb) begin
               cmd.op = OP_STRIP;
            end else begin
               state_in = S_WITNESS;
            end
         end
         S_WITNESS: begin
            if (status.rounds_done) begin
               res_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_WITNESS;
               state_in = S_REDUCE;
            end
         end
         S_REDUCE: begin
            if (status.a_ge_n) begin
               cmd.op = OP_REDUCE;
            end else if (status.a_zero) begin
               cmd.op   = OP_NEXT_ROUND;
               state_in = S_WITNESS;
            end else begin
               cmd.op   = OP_POW_INIT;
               state_in = S_POW_BIT;
            end
         end
         S_POW_BIT: begin
            if (status.e_zero) begin
               state_in = S_SQ_CHECK;
            end else if (status.e_lsb) begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MSEL_ACC_BASE;
               state_in      = S_WAIT_ACC;
            end else begin
               state_in = S_POW_SQR;
            end
         end
         S_WAIT_ACC: begin
            if (status.mul_done) begin
               cmd.op   = OP_WB_ACC;
               state_in = S_POW_SQR;
            end
         end
         S_POW_SQR: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MSEL_BASE_BASE;
            state_in      = S_WAIT_BASE;
         end
         S_WAIT_BASE: begin
            cmd.mul_sel = MSEL_BASE_BASE;
            if (status.mul_done) begin
               cmd.op   = OP_WB_BASE;
               state_in = S_POW_BIT;
            end
         end
         S_SQ_CHECK: begin
            if (status.j_eq_d) begin
               if (status.acc_one) begin
                  cmd.op   = OP_NEXT_ROUND;
                  state_in = S_WITNESS;
               end else begin
                  res_in   = 1'b0;
                  state_in = S_DONE;
               end
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MSEL_ACC_ACC;
               state_in      = S_WAIT_SQ;
            end
         end
         S_WAIT_SQ: begin
            cmd.mul_sel = MSEL_ACC_ACC;
            if (status.mul_done) begin
               if (status.sq_fail) begin
                  res_in   = 1'b0;
                  state_in = S_DONE;
               end else begin
                  cmd.op   = OP_WB_SQ;
                  state_in = S_SQ_CHECK;
               end
            end
         end
         S_DONE: begin
            // hold the answer until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               is_prime_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_ff      <= res_in;
      is_prime_ff <= is_prime_in;
   end

endmodule

// ===== rtl/miller_rabin_primality_test_unit.sv =====
// Top level of the Miller-Rabin primality test unit.
//
// req_candidate is taken on req_valid & req_ready; rsp_is_prime is offered
// on rsp_valid until rsp_ready. One candidate is worked on at a time: req_ready
// is high only while the sequencer is idle, and a finished answer is parked in
// the output register so the next candidate may enter while it waits.
// Values below two, two itself and even values are answered from the classify
// state without running any round. Odd values first strip each factor of two
// from n-1, then per round run a modular power and the trailing squarings.
// Each modular multiplication steps through the significant bits of its second
// operand in the shared shift-and-add multiplier, which sets the rate.
// The round count is written through csr_write_enable/csr_write_data while the
// unit is idle; 0 acts as 1 and values above ten act as ten.
// Reset sets the round count to ten, empties the output register and returns
// the sequencer to idle. A stalled receiver holds the answer in place and
// keeps the next finished item in the sequencer until the register frees.
module miller_rabin_primality_test_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [mrpt_pkg::CAND_WIDTH-1:0]   req_candidate,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_is_prime,
   input  logic                              csr_write_enable,
   input  logic [mrpt_pkg::CFG_WIDTH-1:0]    csr_write_data
);
   import mrpt_pkg::*;

   cmd_type    cmd;
   status_type status;

   mrpt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_is_prime (rsp_is_prime),
      .cmd          (cmd),
      .status       (status)
   );

   mrpt_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_candidate    (req_candidate),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

endmodule
